// ----- hw/rtl/ncb_pkg.sv -----
// shared widths, latency and sideband type of the normalized cross bandpass core
package ncb_pkg;

   // input component width
   localparam int SAMPLE_WIDTH = 16;
   // result component width
   localparam int OUT_WIDTH    = 17;

   // cross and self products, station magnitudes, numerator magnitudes
   localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;
   localparam int MAG_WIDTH    = 2 * SAMPLE_WIDTH;
   // product of the two magnitudes
   localparam int PWR_WIDTH    = 4 * SAMPLE_WIDTH - 1;
   // quotient 16*num^4 / pwr, bounded by 16*pwr
   localparam int QUOT_WIDTH   = 4 * SAMPLE_WIDTH + 3;
   // first and second square root widths
   localparam int ROOT1_WIDTH  = (QUOT_WIDTH + 1) / 2;
   localparam int ROOT2_WIDTH  = ROOT1_WIDTH / 2;
   // signed working width of the final result
   localparam int SIGN_WIDTH   = (ROOT2_WIDTH + 1 > OUT_WIDTH) ? ROOT2_WIDTH + 1 : OUT_WIDTH;

   // front end stages, lane product stages, divider, two roots, output stage
   localparam int CORE_LATENCY = 4 + 3 + QUOT_WIDTH + ROOT1_WIDTH + ROOT2_WIDTH + 1;

   // sideband that travels with each transaction through a lane
   typedef struct packed {
      logic last;
      logic zero;
      logic neg;
   } ncb_tag_type;

endpackage

// ----- hw/rtl/normalized_cross_bandpass_core.sv -----
// top level: cross product of two station bandpasses normalized by the geometric mean
//
// channel   direction  handshake                      payload
// request   in         start & !busy                  req_real_one, req_imag_one,
//                                                     req_real_two, req_imag_two,
//                                                     req_last_channel
// response  out        rsp_valid, one-cycle strobe    rsp_avg_real, rsp_avg_imag,
//                                                     rsp_zero_power, rsp_last_out
//
// one transaction enters every cycle that start is high; busy is always low
// the pipeline has four front end stages, three product stages, one divider stage per quotient bit,
// one root stage per root bit and one output stage
// synchronous active-high reset clears the valid bits; payload registers are not reset
// the response side cannot stall, so nothing is held back inside the pipeline
module normalized_cross_bandpass_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [ncb_pkg::SAMPLE_WIDTH-1:0] req_real_one,
   input  logic signed [ncb_pkg::SAMPLE_WIDTH-1:0] req_imag_one,
   input  logic signed [ncb_pkg::SAMPLE_WIDTH-1:0] req_real_two,
   input  logic signed [ncb_pkg::SAMPLE_WIDTH-1:0] req_imag_two,
   input  logic                                    req_last_channel,
   output logic                                    rsp_valid,
   output logic signed [ncb_pkg::OUT_WIDTH-1:0]    rsp_avg_real,
   output logic signed [ncb_pkg::OUT_WIDTH-1:0]    rsp_avg_imag,
   output logic                                    rsp_zero_power,
   output logic                                    rsp_last_out
);

   localparam int W  = ncb_pkg::SAMPLE_WIDTH;
   localparam int PR = ncb_pkg::PROD_WIDTH;
   localparam int MW = ncb_pkg::MAG_WIDTH;
   localparam int PW = ncb_pkg::PWR_WIDTH;

   assign busy = 1'b0;

   // input registers
   logic                vi_ff;
   logic                last1_ff;
   logic signed [W-1:0] r1_ff, i1_ff, r2_ff, i2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vi_ff <= 1'b0;
      end else begin
         vi_ff <= start & ~busy;
      end
      r1_ff    <= req_real_one;
      i1_ff    <= req_imag_one;
      r2_ff    <= req_real_two;
      i2_ff    <= req_imag_two;
      last1_ff <= req_last_channel;
   end

   // cross and self products
   logic                 vp_ff;
   logic                 last2_ff;
   logic signed [PR-1:0] rr_ff, ii_ff, ri_ff, ir_ff, a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [PR-1:0] rr_in, ii_in, ri_in, ir_in, a1_in, b1_in, a2_in, b2_in;

   assign rr_in = r1_ff * r2_ff;
   assign ii_in = i1_ff * i2_ff;
   assign ri_in = r2_ff * i1_ff;
   assign ir_in = r1_ff * i2_ff;
   assign a1_in = r1_ff * r1_ff;
   assign b1_in = i1_ff * i1_ff;
   assign a2_in = r2_ff * r2_ff;
   assign b2_in = i2_ff * i2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else begin
         vp_ff <= vi_ff;
      end
      last2_ff <= last1_ff;
      rr_ff    <= rr_in;
      ii_ff    <= ii_in;
      ri_ff    <= ri_in;
      ir_ff    <= ir_in;
      a1_ff    <= a1_in;
      b1_ff    <= b1_in;
      a2_ff    <= a2_in;
      b2_ff    <= b2_in;
   end

   // numerators and station magnitudes
   logic               vs_ff;
   logic               last3_ff;
   logic signed [PR:0] num_re_ff, num_im_ff;
   logic signed [PR:0] num_re_in, num_im_in;
   logic [MW-1:0]      m1_ff, m2_ff;
   logic [MW-1:0]      m1_in, m2_in;

   assign num_re_in = (PR+1)'(rr_ff) + (PR+1)'(ii_ff);
   assign num_im_in = (PR+1)'(ri_ff) - (PR+1)'(ir_ff);
   assign m1_in     = $unsigned(a1_ff) + $unsigned(b1_ff);
   assign m2_in     = $unsigned(a2_ff) + $unsigned(b2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= 1'b0;
      end else begin
         vs_ff <= vp_ff;
      end
      last3_ff  <= last2_ff;
      num_re_ff <= num_re_in;
      num_im_ff <= num_im_in;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
   end

   // power product, numerator magnitudes and lane sideband
   logic                 vm_ff;
   ncb_pkg::ncb_tag_type tag_re_ff, tag_im_ff;
   ncb_pkg::ncb_tag_type tag_re_in, tag_im_in;
   logic [PW-1:0]        pwr_ff;
   logic [2*MW-1:0]      pwr_full;
   logic [MW-1:0]        mag_re_ff, mag_im_ff;
   logic [PR:0]          abs_re, abs_im;
   logic                 zero_in;

   assign pwr_full = m1_ff * m2_ff;
   assign zero_in  = (m1_ff == '0) || (m2_ff == '0);
   assign abs_re   = num_re_ff[PR] ? (PR+1)'(0) - num_re_ff : num_re_ff;
   assign abs_im   = num_im_ff[PR] ? (PR+1)'(0) - num_im_ff : num_im_ff;

   always_comb begin
      tag_re_in.last = last3_ff;
      tag_re_in.zero = zero_in;
      tag_re_in.neg  = num_re_ff[PR];
      tag_im_in.last = last3_ff;
      tag_im_in.zero = zero_in;
      tag_im_in.neg  = num_im_ff[PR];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else begin
         vm_ff <= vs_ff;
      end
      tag_re_ff <= tag_re_in;
      tag_im_ff <= tag_im_in;
      pwr_ff    <= pwr_full[PW-1:0];
      mag_re_ff <= abs_re[MW-1:0];
      mag_im_ff <= abs_im[MW-1:0];
   end

   // one lane per result component
   logic                         re_valid, im_valid;
   ncb_pkg::ncb_tag_type         re_tag, im_tag;
   logic signed [ncb_pkg::OUT_WIDTH-1:0] re_value, im_value;

   ncb_lane u_lane_re (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vm_ff),
      .in_tag    (tag_re_ff),
      .in_mag    (mag_re_ff),
      .in_pwr    (pwr_ff),
      .out_valid (re_valid),
      .out_tag   (re_tag),
      .out_value (re_value)
   );

   ncb_lane u_lane_im (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vm_ff),
      .in_tag    (tag_im_ff),
      .in_mag    (mag_im_ff),
      .in_pwr    (pwr_ff),
      .out_valid (im_valid),
      .out_tag   (im_tag),
      .out_value (im_value)
   );

   // response ports
   assign rsp_valid      = re_valid;
   assign rsp_avg_real   = re_value;
   assign rsp_avg_imag   = im_value;
   assign rsp_zero_power = re_tag.zero;
   assign rsp_last_out   = re_tag.last;

   // checks
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (re_valid == im_valid) && (!re_valid || (re_tag.zero == im_tag.zero
         && re_tag.last == im_tag.last)))
      else $error("result lanes out of step");

   a_rsp_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, ncb_pkg::CORE_LATENCY))
      else $error("response without a request transaction");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_out == $past(req_last_channel, ncb_pkg::CORE_LATENCY))
      else $error("last channel marker lost");

   a_zero_forces: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_power |-> rsp_avg_real == '0 && rsp_avg_imag == '0)
      else $error("zero power result not cleared");

endmodule

// ----- hw/rtl/ncb_lane.sv -----
// one result component: rounds num / (m1*m2)^(1/4) through divider and two root pipelines
module ncb_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  ncb_pkg::ncb_tag_type                 in_tag,
   input  logic [ncb_pkg::MAG_WIDTH-1:0]        in_mag,
   input  logic [ncb_pkg::PWR_WIDTH-1:0]        in_pwr,
   output logic                                 out_valid,
   output ncb_pkg::ncb_tag_type                 out_tag,
   output logic signed [ncb_pkg::OUT_WIDTH-1:0] out_value
);

   localparam int MW  = ncb_pkg::MAG_WIDTH;
   localparam int SW  = 2 * MW;
   localparam int HW  = SW / 2;
   localparam int DW  = 4 * MW + 4;
   localparam int PW  = ncb_pkg::PWR_WIDTH;
   localparam int QW  = ncb_pkg::QUOT_WIDTH;
   localparam int S1  = ncb_pkg::ROOT1_WIDTH;
   localparam int S2  = ncb_pkg::ROOT2_WIDTH;
   localparam int RM1 = S1 + 3;
   localparam int RM2 = S2 + 3;
   localparam int XW  = ncb_pkg::SIGN_WIDTH;
   localparam int OW  = ncb_pkg::OUT_WIDTH;

   // square of the numerator magnitude
   logic                 sq_vld_ff;
   ncb_pkg::ncb_tag_type sq_tag_ff;
   logic [SW-1:0]        sq_ff;
   logic [SW-1:0]        sq_in;
   logic [PW-1:0]        sq_pwr_ff;

   assign sq_in = in_mag * in_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= in_valid;
      end
      sq_tag_ff <= in_tag;
      sq_ff     <= sq_in;
      sq_pwr_ff <= in_pwr;
   end

   // partial products of the square squared
   logic                 pp_vld_ff;
   ncb_pkg::ncb_tag_type pp_tag_ff;
   logic [PW-1:0]        pp_pwr_ff;
   logic [SW-1:0]        hh_ff, hl_ff, ll_ff;
   logic [SW-1:0]        hh_in, hl_in, ll_in;

   assign hh_in = sq_ff[SW-1:HW] * sq_ff[SW-1:HW];
   assign hl_in = sq_ff[SW-1:HW] * sq_ff[HW-1:0];
   assign ll_in = sq_ff[HW-1:0] * sq_ff[HW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_vld_ff <= 1'b0;
      end else begin
         pp_vld_ff <= sq_vld_ff;
      end
      pp_tag_ff <= sq_tag_ff;
      pp_pwr_ff <= sq_pwr_ff;
      hh_ff     <= hh_in;
      hl_ff     <= hl_in;
      ll_ff     <= ll_in;
   end

   // dividend 16*num^4
   logic                 ac_vld_ff;
   ncb_pkg::ncb_tag_type ac_tag_ff;
   logic [PW-1:0]        ac_pwr_ff;
   logic [DW-1:0]        acc_ff;
   logic [DW-1:0]        acc_in;

   assign acc_in = (DW'(hh_ff) << (SW + 4)) + (DW'(hl_ff) << (HW + 5)) + (DW'(ll_ff) << 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_vld_ff <= 1'b0;
      end else begin
         ac_vld_ff <= pp_vld_ff;
      end
      ac_tag_ff <= pp_tag_ff;
      ac_pwr_ff <= pp_pwr_ff;
      acc_ff    <= acc_in;
   end

   // restoring divider, one quotient bit per stage
   logic                 dv_vld_ff  [0:QW-1];
   ncb_pkg::ncb_tag_type dv_tag_ff  [0:QW-1];
   logic [PW-1:0]        dv_rem_ff  [0:QW-1];
   logic [QW-1:0]        dv_word_ff [0:QW-1];
   logic [PW-1:0]        dv_pwr_ff  [0:QW-1];

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic                 vld_src;
      ncb_pkg::ncb_tag_type tag_src;
      logic [PW-1:0]        rem_src;
      logic [QW-1:0]        word_src;
      logic [PW-1:0]        pwr_src;
      logic [PW:0]          cat;
      logic                 ge;

      if (k == 0) begin : g_head
         assign vld_src  = ac_vld_ff;
         assign tag_src  = ac_tag_ff;
         assign rem_src  = acc_ff[QW+PW-1:QW];
         assign word_src = acc_ff[QW-1:0];
         assign pwr_src  = ac_pwr_ff;
      end else begin : g_tail
         assign vld_src  = dv_vld_ff[k-1];
         assign tag_src  = dv_tag_ff[k-1];
         assign rem_src  = dv_rem_ff[k-1];
         assign word_src = dv_word_ff[k-1];
         assign pwr_src  = dv_pwr_ff[k-1];
      end

      assign cat = {rem_src, word_src[QW-1]};
      assign ge  = cat >= {1'b0, pwr_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else begin
            dv_vld_ff[k] <= vld_src;
         end
         dv_tag_ff[k]  <= tag_src;
         dv_rem_ff[k]  <= ge ? PW'(cat - {1'b0, pwr_src}) : cat[PW-1:0];
         dv_word_ff[k] <= {word_src[QW-2:0], ge};
         dv_pwr_ff[k]  <= pwr_src;
      end
   end

   // first square root of the quotient, one root bit per stage
   logic                 r1_vld_ff  [0:S1-1];
   ncb_pkg::ncb_tag_type r1_tag_ff  [0:S1-1];
   logic [RM1-1:0]       r1_rem_ff  [0:S1-1];
   logic [2*S1-1:0]      r1_rad_ff  [0:S1-1];
   logic [S1-1:0]        r1_root_ff [0:S1-1];

   for (genvar k = 0; k < S1; k++) begin : g_root1
      logic                 vld_src;
      ncb_pkg::ncb_tag_type tag_src;
      logic [RM1-1:0]       rem_src;
      logic [2*S1-1:0]      rad_src;
      logic [S1-1:0]        root_src;
      logic [RM1-1:0]       cat;
      logic [RM1-1:0]       trial;
      logic                 ge;

      if (k == 0) begin : g_head
         assign vld_src  = dv_vld_ff[QW-1];
         assign tag_src  = dv_tag_ff[QW-1];
         assign rem_src  = '0;
         assign rad_src  = (2*S1)'(dv_word_ff[QW-1]);
         assign root_src = '0;
      end else begin : g_tail
         assign vld_src  = r1_vld_ff[k-1];
         assign tag_src  = r1_tag_ff[k-1];
         assign rem_src  = r1_rem_ff[k-1];
         assign rad_src  = r1_rad_ff[k-1];
         assign root_src = r1_root_ff[k-1];
      end

      assign cat   = {rem_src[RM1-3:0], rad_src[2*S1-1 -: 2]};
      assign trial = {(RM1-2)'(root_src), 2'b01};
      assign ge    = cat >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            r1_vld_ff[k] <= 1'b0;
         end else begin
            r1_vld_ff[k] <= vld_src;
         end
         r1_tag_ff[k]  <= tag_src;
         r1_rem_ff[k]  <= ge ? cat - trial : cat;
         r1_rad_ff[k]  <= {rad_src[2*S1-3:0], 2'b00};
         r1_root_ff[k] <= {root_src[S1-2:0], ge};
      end
   end

   // second square root gives the fourth root
   logic                 r2_vld_ff  [0:S2-1];
   ncb_pkg::ncb_tag_type r2_tag_ff  [0:S2-1];
   logic [RM2-1:0]       r2_rem_ff  [0:S2-1];
   logic [2*S2-1:0]      r2_rad_ff  [0:S2-1];
   logic [S2-1:0]        r2_root_ff [0:S2-1];

   for (genvar k = 0; k < S2; k++) begin : g_root2
      logic                 vld_src;
      ncb_pkg::ncb_tag_type tag_src;
      logic [RM2-1:0]       rem_src;
      logic [2*S2-1:0]      rad_src;
      logic [S2-1:0]        root_src;
      logic [RM2-1:0]       cat;
      logic [RM2-1:0]       trial;
      logic                 ge;

      if (k == 0) begin : g_head
         assign vld_src  = r1_vld_ff[S1-1];
         assign tag_src  = r1_tag_ff[S1-1];
         assign rem_src  = '0;
         assign rad_src  = (2*S2)'(r1_root_ff[S1-1]);
         assign root_src = '0;
      end else begin : g_tail
         assign vld_src  = r2_vld_ff[k-1];
         assign tag_src  = r2_tag_ff[k-1];
         assign rem_src  = r2_rem_ff[k-1];
         assign rad_src  = r2_rad_ff[k-1];
         assign root_src = r2_root_ff[k-1];
      end

      assign cat   = {rem_src[RM2-3:0], rad_src[2*S2-1 -: 2]};
      assign trial = {(RM2-2)'(root_src), 2'b01};
      assign ge    = cat >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            r2_vld_ff[k] <= 1'b0;
         end else begin
            r2_vld_ff[k] <= vld_src;
         end
         r2_tag_ff[k]  <= tag_src;
         r2_rem_ff[k]  <= ge ? cat - trial : cat;
         r2_rad_ff[k]  <= {rad_src[2*S2-3:0], 2'b00};
         r2_root_ff[k] <= {root_src[S2-2:0], ge};
      end
   end

   // largest n with 2n-1 at most the fourth root, then sign and zero forcing
   logic                 fin_vld_ff;
   ncb_pkg::ncb_tag_type fin_tag_ff;
   logic [OW-1:0]        fin_value_ff;
   logic [OW-1:0]        fin_value_in;
   logic [S2:0]          n_sum;
   logic [XW-1:0]        n_ext;
   logic [XW-1:0]        n_sgn;

   assign n_sum = {1'b0, r2_root_ff[S2-1]} + (S2+1)'(1);
   assign n_ext = XW'(n_sum[S2:1]);
   assign n_sgn = r2_tag_ff[S2-1].neg ? XW'(0) - n_ext : n_ext;
   assign fin_value_in = r2_tag_ff[S2-1].zero ? '0 : n_sgn[OW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else begin
         fin_vld_ff <= r2_vld_ff[S2-1];
      end
      fin_tag_ff   <= r2_tag_ff[S2-1];
      fin_value_ff <= fin_value_in;
   end

   assign out_valid = fin_vld_ff;
   assign out_tag   = fin_tag_ff;
   assign out_value = $signed(fin_value_ff);

endmodule

// ----- test/tb_top.sv -----
// testbench for the normalized cross bandpass core: directed table plus random channels
`timescale 1ns / 1ps

module tb_top;

   localparam int  SAMPLE_WIDTH = ncb_pkg::SAMPLE_WIDTH;
   localparam int  OUT_WIDTH    = ncb_pkg::OUT_WIDTH;
   localparam int  ITEM_COUNT   = 550;
   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  DRAIN        = ncb_pkg::CORE_LATENCY + 20;

   // one expected response
   typedef struct {
      logic signed [OUT_WIDTH-1:0] avg_real;
      logic signed [OUT_WIDTH-1:0] avg_imag;
      logic                        zero_power;
      logic                        last_out;
   } cross_result_type;

   // one directed channel, with an optional typed-in answer
   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] r1, i1, r2, i2;
      logic                           last;
      bit                             typed;
      cross_result_type               answer;
   } channel_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [SAMPLE_WIDTH-1:0] req_real_one = '0, req_imag_one = '0;
   logic signed [SAMPLE_WIDTH-1:0] req_real_two = '0, req_imag_two = '0;
   logic req_last_channel = 1'b0;
   logic rsp_valid;
   logic signed [OUT_WIDTH-1:0] rsp_avg_real, rsp_avg_imag;
   logic rsp_zero_power, rsp_last_out;

   cross_result_type pending_results[$];
   int               error_count = 0;
   int               result_count = 0;
   int               zero_count = 0;
   int               cycle_count = 0;
   int               idle_pct = 0;

   normalized_cross_bandpass_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_real_one(req_real_one), .req_imag_one(req_imag_one),
      .req_real_two(req_real_two), .req_imag_two(req_imag_two),
      .req_last_channel(req_last_channel),
      .rsp_valid(rsp_valid), .rsp_avg_real(rsp_avg_real), .rsp_avg_imag(rsp_avg_imag),
      .rsp_zero_power(rsp_zero_power), .rsp_last_out(rsp_last_out)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("FAIL");
         $finish;
      end
   end

   // nearest integer to num / p^(1/4), ties away from zero, by exact fourth powers
   function automatic longint scaled_root_quotient(longint num, logic [255:0] pwr);
      logic [255:0] lhs, rhs, dd;
      longint mag, lo, hi, mid;
      if (num == 0) return 0;
      mag = (num < 0) ? -num : num;
      lhs = 256'(mag);
      lhs = lhs * lhs;
      lhs = lhs * lhs * 256'd16;
      lo  = 0;
      hi  = 65536;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         dd  = 256'(2 * mid - 1);
         dd  = dd * dd;
         rhs = dd * dd * pwr;
         if (lhs >= rhs) lo = mid;
         else hi = mid - 1;
      end
      return (num < 0) ? -lo : lo;
   endfunction

   // expected response of one channel
   function automatic cross_result_type predict_cross(channel_row_type row);
      cross_result_type res;
      longint r1, i1, r2, i2, m1, m2, re, im;
      logic [255:0] pwr;
      r1 = row.r1; i1 = row.i1; r2 = row.r2; i2 = row.i2;
      m1 = r1 * r1 + i1 * i1;
      m2 = r2 * r2 + i2 * i2;
      re = 0;
      im = 0;
      res.zero_power = (m1 == 0 || m2 == 0);
      if (!res.zero_power) begin
         pwr = 256'(m1) * 256'(m2);
         re  = scaled_root_quotient(r1 * r2 + i1 * i2, pwr);
         im  = scaled_root_quotient(r2 * i1 - r1 * i2, pwr);
      end
      res.avg_real = re[OUT_WIDTH-1:0];
      res.avg_imag = im[OUT_WIDTH-1:0];
      res.last_out = row.last;
      return res;
   endfunction

   // present one transaction after random idle cycles, wait for acceptance
   task automatic send_channel(channel_row_type row);
      cross_result_type exp_res;
      exp_res = row.typed ? row.answer : predict_cross(row);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_real_one     <= row.r1;
      req_imag_one     <= row.i1;
      req_real_two     <= row.r2;
      req_imag_two     <= row.i2;
      req_last_channel <= row.last;
      do @(posedge clock); while (busy);
      pending_results.push_back(exp_res);
      @(negedge clock);
   endtask

   // random component: full range, small, extreme or zero
   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         2, 3:    return SAMPLE_WIDTH'($signed($urandom_range(8)) - 4);
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      cross_result_type exp_res;
      if (!reset && rsp_valid) begin
         result_count <= result_count + 1;
         if (rsp_zero_power) zero_count <= zero_count + 1;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transaction re=%0d im=%0d zp=%0b last=%0b",
                     $time, rsp_avg_real, rsp_avg_imag, rsp_zero_power, rsp_last_out);
            error_count <= error_count + 1;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_avg_real !== exp_res.avg_real || rsp_avg_imag !== exp_res.avg_imag ||
                rsp_zero_power !== exp_res.zero_power || rsp_last_out !== exp_res.last_out) begin
               $display("%0t: mismatch expected re=%0d im=%0d zp=%0b last=%0b", $time,
                        exp_res.avg_real, exp_res.avg_imag, exp_res.zero_power,
                        exp_res.last_out);
               $display("%0t:          actual   re=%0d im=%0d zp=%0b last=%0b", $time,
                        rsp_avg_real, rsp_avg_imag, rsp_zero_power, rsp_last_out);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // stimulus
   initial begin
      channel_row_type directed[$];
      channel_row_type row;
      int              wait_cycles;

      // zero magnitude on either side, unit and extreme magnitudes, conjugate phase
      directed = '{
         '{0, 0, 0, 0, 1'b0, 1'b1, '{0, 0, 1'b1, 1'b0}},
         '{0, 0, 100, -7, 1'b1, 1'b1, '{0, 0, 1'b1, 1'b1}},
         '{-32768, 32767, 0, 0, 1'b0, 1'b1, '{0, 0, 1'b1, 1'b0}},
         '{1, 0, 1, 0, 1'b0, 1'b1, '{1, 0, 1'b0, 1'b0}},
         '{0, 1, 1, 0, 1'b1, 1'b1, '{0, 1, 1'b0, 1'b1}},
         '{32767, 0, 32767, 0, 1'b0, 1'b1, '{32767, 0, 1'b0, 1'b0}},
         '{-32768, -32768, -32768, -32768, 1'b0, 1'b1, '{46341, 0, 1'b0, 1'b0}},
         '{0, -32768, -32768, 0, 1'b1, 1'b1, '{0, 32768, 1'b0, 1'b1}},
         '{-32768, -32768, -32768, 32767, 1'b0, 1'b0, '{0, 0, 1'b0, 1'b0}},
         '{32767, 32767, -32768, -32768, 1'b1, 1'b0, '{0, 0, 1'b0, 1'b0}},
         '{-32768, 0, 0, 32767, 1'b0, 1'b0, '{0, 0, 1'b0, 1'b0}},
         '{-1, -1, 1, 1, 1'b0, 1'b0, '{0, 0, 1'b0, 1'b0}},
         '{3, -4, -5, 12, 1'b1, 1'b0, '{0, 0, 1'b0, 1'b0}},
         '{1, 1, 32767, -32768, 1'b0, 1'b0, '{0, 0, 1'b0, 1'b0}},
         '{21845, -10923, 2, 1, 1'b1, 1'b0, '{0, 0, 1'b0, 1'b0}}
      };

      // synchronous reset, released on a falling clock edge
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[k]) send_channel(directed[k]);

      // random channels across idling phases
      for (int n = 0; n < ITEM_COUNT; n++) begin
         case (n * 4 / ITEM_COUNT)
            0:       idle_pct = 0;
            1:       idle_pct = 88;
            2:       idle_pct = 24;
            default: idle_pct = (n % 100 < 50) ? 0 : 88;
         endcase
         row.r1    = random_sample();
         row.i1    = random_sample();
         row.r2    = random_sample();
         row.i2    = random_sample();
         row.last  = $urandom_range(1);
         row.typed = 1'b0;
         send_channel(row);
      end
      start <= 1'b0;

      // drain the pipeline
      while (pending_results.size() != 0) @(posedge clock);
      wait_cycles = 0;
      while (wait_cycles < DRAIN) begin
         @(posedge clock);
         wait_cycles++;
      end

      $display("covered %0d directed and %0d random channels, %0d responses checked",
               directed.size(), ITEM_COUNT, result_count);
      $display("%0d responses flagged zero power, %0d errors", zero_count, error_count);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
